>>> sv/bpu_pkg.sv
// bpu_pkg: shared types, register codes and mask decode for the bitfield pixel unpacker.
// No dependencies; used by bitfield_pixel_unpack, bpu_cfg and bpu_cell.
`default_nettype none

package bpu_pkg;

  localparam int NCHAN    = 4;
  localparam int NCELLS   = 8;        // one quotient bit per cell
  localparam int REM_W    = 40;       // holds word_field * 255
  localparam int WORD_W   = 32;
  localparam int CHAN_W   = 8;
  localparam int CFG_IDX_W = 3;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_ALPHA = 3;

  localparam logic [WORD_W-1:0] RST_MASK_RED   = 32'h00FF_0000;
  localparam logic [WORD_W-1:0] RST_MASK_GREEN = 32'h0000_FF00;
  localparam logic [WORD_W-1:0] RST_MASK_BLUE  = 32'h0000_00FF;
  localparam logic [WORD_W-1:0] RST_MASK_ALPHA = 32'h0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASK_RED    = 3'd0,
    REG_MASK_GREEN  = 3'd1,
    REG_MASK_BLUE   = 3'd2,
    REG_MASK_ALPHA  = 3'd3,
    REG_WIDE_PIXELS = 3'd4
  } reg_idx_t;

  // Decoded channel setup. div is the lowest run of ones of the mask, left in place:
  // the shift cancels in (word & mask) * 255 / div.
  typedef struct packed {
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] div;
    logic              fill;   // zero alpha mask: force 255
  } chan_cfg_t;

  typedef struct packed {
    chan_cfg_t [NCHAN-1:0] ch;
    logic                  wide;
  } cfg_t;

  // One channel in flight through the divider row.
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [WORD_W-1:0] div;
    logic [CHAN_W-1:0] quo;
    logic              sat;
  } lane_t;

  function automatic chan_cfg_t decode_mask(input logic [WORD_W-1:0] m, input logic is_alpha);
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] run;
    chan_cfg_t         c;
    low = m & (~m + 32'd1);
    // adding the low bit carries through the first run and clears it
    run = m & ~(m + low);
    c.mask = m;
    c.div  = run | {31'd0, (m == '0)};
    c.fill = is_alpha & (m == '0);
    return c;
  endfunction

endpackage

`default_nettype wire

>>> sv/bitfield_pixel_unpack.sv
// bitfield_pixel_unpack: bitfield pixel word to 8-bit RGBA, one word per clock.
// Depends on bpu_pkg, bpu_cfg, bpu_cell.
//
//   channel | dir | handshake          | payload
//   s_*     | in  | s_tvalid/s_tready  | s_tdata[31:0]  pixel_word
//   m_*     | out | m_tvalid/m_tready  | m_tdata[31:0]  red, green, blue, alpha
//   cfg_*   | in  | cfg_wen            | cfg_index, cfg_data
//
// Pipeline: one prep register, then a row of 8 divider cells per channel.
// Throughput one word per cycle while m_tready is high; each stage moves when it is empty or
// its successor moves; bubbles close up, so input can enter while a result waits at the output.
// rst is synchronous: clears the stage valids, loads the mask reset values, sets wide mode.
`default_nettype none

module bitfield_pixel_unpack (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] pixel_word
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  input  wire logic        cfg_wen,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int NST = bpu_pkg::NCELLS + 1;

  bpu_pkg::cfg_t  cfg;
  bpu_pkg::lane_t st [NST][bpu_pkg::NCHAN];
  logic [NST-1:0] vld;
  logic [NST-1:0] rdy;
  logic [31:0]    word;

  bpu_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_comb begin
    rdy[NST-1] = ~vld[NST-1] | m_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = ~vld[k] | rdy[k+1];
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign word = cfg.wide ? s_tdata : {16'd0, s_tdata[15:0]};

  for (genvar c = 0; c < bpu_pkg::NCHAN; c++) begin : g_chan
    logic [31:0] field;

    // field bits beyond the first run of the mask push the ratio over one
    assign field = word & cfg.ch[c].mask;

    always_ff @(posedge clk) begin
      if (rdy[0]) begin
        st[0][c].rem <= {field, 8'd0} - {8'd0, field};
        st[0][c].div <= cfg.ch[c].div;
        st[0][c].quo <= '0;
        st[0][c].sat <= (field > cfg.ch[c].div) | cfg.ch[c].fill;
      end
    end

    for (genvar k = 1; k < NST; k++) begin : g_cell
      bpu_cell u_cell (
        .clk (clk),
        .en  (rdy[k]),
        .d   (st[k-1][c]),
        .q   (st[k][c])
      );
    end

    assign m_tdata[c*8 +: 8] = st[NST-1][c].sat ? 8'hFF : st[NST-1][c].quo;
  end

endmodule

`default_nettype wire

>>> sv/bpu_cfg.sv
// bpu_cfg: mask and mode registers; decodes each mask into its divisor on write.
// Depends on bpu_pkg.
`default_nettype none

module bpu_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wen,
  input  wire logic [bpu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bpu_pkg::WORD_W-1:0]    cfg_data,
  output bpu_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ch[bpu_pkg::CH_RED]   <= bpu_pkg::decode_mask(bpu_pkg::RST_MASK_RED, 1'b0);
      cfg.ch[bpu_pkg::CH_GREEN] <= bpu_pkg::decode_mask(bpu_pkg::RST_MASK_GREEN, 1'b0);
      cfg.ch[bpu_pkg::CH_BLUE]  <= bpu_pkg::decode_mask(bpu_pkg::RST_MASK_BLUE, 1'b0);
      cfg.ch[bpu_pkg::CH_ALPHA] <= bpu_pkg::decode_mask(bpu_pkg::RST_MASK_ALPHA, 1'b1);
      cfg.wide <= 1'b1;
    end else if (cfg_wen) begin
      unique case (bpu_pkg::reg_idx_t'(cfg_index))
        bpu_pkg::REG_MASK_RED:
          cfg.ch[bpu_pkg::CH_RED] <= bpu_pkg::decode_mask(cfg_data, 1'b0);
        bpu_pkg::REG_MASK_GREEN:
          cfg.ch[bpu_pkg::CH_GREEN] <= bpu_pkg::decode_mask(cfg_data, 1'b0);
        bpu_pkg::REG_MASK_BLUE:
          cfg.ch[bpu_pkg::CH_BLUE] <= bpu_pkg::decode_mask(cfg_data, 1'b0);
        bpu_pkg::REG_MASK_ALPHA:
          cfg.ch[bpu_pkg::CH_ALPHA] <= bpu_pkg::decode_mask(cfg_data, 1'b1);
        bpu_pkg::REG_WIDE_PIXELS:
          cfg.wide <= cfg_data[0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/bpu_cell.sv
// bpu_cell: one restoring-division step for one channel; retires one quotient bit.
// Depends on bpu_pkg.
`default_nettype none

module bpu_cell (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire bpu_pkg::lane_t d,
  output bpu_pkg::lane_t      q
);

  logic [bpu_pkg::REM_W-1:0] dsh;
  logic [bpu_pkg::REM_W:0]   diff;
  logic                      take;
  logic [bpu_pkg::REM_W-1:0] rem_next;

  // divisor aligned to the top quotient bit; remainder shifts up each step
  assign dsh      = {1'b0, d.div, 7'd0};
  assign diff     = {1'b0, d.rem} - {1'b0, dsh};
  assign take     = ~diff[bpu_pkg::REM_W];
  assign rem_next = take ? diff[bpu_pkg::REM_W-1:0] : d.rem;

  always_ff @(posedge clk) begin
    if (en) begin
      q.rem <= {rem_next[bpu_pkg::REM_W-2:0], 1'b0};
      q.div <= d.div;
      q.quo <= {d.quo[bpu_pkg::CHAN_W-2:0], take};
      q.sat <= d.sat;
    end
  end

endmodule

`default_nettype wire

>>> sv/bpu_checker.sv
// bpu_checker: port-level assertions for bitfield_pixel_unpack, bound to the top level.
// Depends on bitfield_pixel_unpack port list only.
`default_nettype none

module bpu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  logic [3:0] cnt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_tvalid & s_tready;
  assign out_acc = m_tvalid & m_tready;

  // words inside the block
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + {3'd0, in_acc} - {3'd0, out_acc};
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  a_no_block: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while output side is free");

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    (cnt <= 4'd9) && !(cnt == 4'd0 && m_tvalid))
    else $error("words in flight out of range");

endmodule

bind bitfield_pixel_unpack bpu_checker u_bpu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
